>>> rtl/core/wftg_pkg.sv
// Shared types, codes, reset values and helpers for the water fill temperature guard.
`timescale 1ns / 1ps

package wftg_pkg;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int EL_W     = 16;
   localparam int TEMP_W   = 8;
   localparam int CHOICE_W = 2;
   localparam int TIME_W   = 24;
   localparam int FAULT_W  = 3;
   localparam int VALVE_W  = 3;
   localparam int IDX_W    = 3;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 8;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [TEMP_W-1:0] RELEASE_HYST = TEMP_W'(3);

   // Commands
   localparam logic [CMD_W-1:0] CMD_MONITOR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

   // Temperature selections
   localparam logic [CHOICE_W-1:0] CHOICE_COLD = 2'd0;
   localparam logic [CHOICE_W-1:0] CHOICE_WARM = 2'd1;
   localparam logic [CHOICE_W-1:0] CHOICE_HOT  = 2'd2;
   localparam logic [CHOICE_W-1:0] CHOICE_NONE = 2'd3;

   // Fault codes
   localparam logic [FAULT_W-1:0] FAULT_NORMAL     = 3'd0;
   localparam logic [FAULT_W-1:0] FAULT_COLD_ON    = 3'd1;
   localparam logic [FAULT_W-1:0] FAULT_HOT_OFF    = 3'd2;
   localparam logic [FAULT_W-1:0] FAULT_FAILURE    = 3'd3;
   localparam logic [FAULT_W-1:0] FAULT_WRONG_CONN = 3'd4;

   // Valve bit positions
   localparam int VALVE_COLD = 0;
   localparam int VALVE_HOT  = 1;
   localparam int VALVE_SOFT = 2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_COLD_HIGH_TEMP = 3'd0;
   localparam logic [IDX_W-1:0] REG_MAX_TEMP       = 3'd1;
   localparam logic [IDX_W-1:0] REG_WRONG_CONN_TO  = 3'd2;
   localparam logic [IDX_W-1:0] REG_HOT_OFF_TO     = 3'd3;
   localparam logic [IDX_W-1:0] REG_FAILURE_TO     = 3'd4;
   localparam logic [IDX_W-1:0] REG_FILL_DELAY     = 3'd5;
   localparam logic [IDX_W-1:0] REG_SUPPLY_TO      = 3'd6;

   // Register reset values
   localparam logic [TEMP_W-1:0] RST_COLD_HIGH_TEMP = 8'd50;
   localparam logic [TEMP_W-1:0] RST_MAX_TEMP       = 8'd63;
   localparam logic [TIME_W-1:0] RST_WRONG_CONN_TO  = 24'd10000;
   localparam logic [TIME_W-1:0] RST_HOT_OFF_TO     = 24'd30000;
   localparam logic [TIME_W-1:0] RST_FAILURE_TO     = 24'd150000;
   localparam logic [TIME_W-1:0] RST_FILL_DELAY     = 24'd3000;
   localparam logic [TIME_W-1:0] RST_SUPPLY_TO      = 24'd1200000;

   typedef struct packed {
      logic [TEMP_W-1:0] cold_high_temp;
      logic [TEMP_W-1:0] max_temp;
      logic [TIME_W-1:0] wrong_conn_timeout_ms;
      logic [TIME_W-1:0] hot_off_timeout_ms;
      logic [TIME_W-1:0] failure_timeout_ms;
      logic [TIME_W-1:0] start_wait_ms;
      logic [TIME_W-1:0] supply_timeout_ms;
   } cfg_type;

   // Members run from the top bit down, so cmd lands in the lowest bits as on tdata.
   typedef struct packed {
      logic                softener_stage;
      logic [CHOICE_W-1:0] temp_choice;
      logic [TEMP_W-1:0]   water_temp;
      logic [EL_W-1:0]     elapsed_ms;
      logic [CMD_W-1:0]    cmd;
   } item_type;

   // Fill-side state: start delay, supply timer, sticky flag, valve drive.
   typedef struct packed {
      logic [TIME_W-1:0]  start_delay_time;
      logic [TIME_W-1:0]  supply_time;
      logic               supply_fault_flag;
      logic [VALVE_W-1:0] valve_drive;
   } fill_state_type;

   // Monitor-side state: fault code and its two timers.
   typedef struct packed {
      logic [FAULT_W-1:0] fault_code;
      logic [TIME_W-1:0]  wrong_conn_time;
      logic [TIME_W-1:0]  overheat_time;
   } mon_state_type;

   // Saturating add of elapsed milliseconds to a timer.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [EL_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {{(TIME_W+1-EL_W){1'b0}}, b};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

endpackage

>>> rtl/core/wftg_csr.sv
// Configuration register file for the water fill temperature guard.
`timescale 1ns / 1ps

module wftg_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [wftg_pkg::IDX_W-1:0]  csr_index,
   input  logic [wftg_pkg::TIME_W-1:0] csr_data,
   output wftg_pkg::cfg_type         cfg
);
   import wftg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_COLD_HIGH_TEMP: cfg_in.cold_high_temp        = csr_data[TEMP_W-1:0];
            REG_MAX_TEMP:       cfg_in.max_temp              = csr_data[TEMP_W-1:0];
            REG_WRONG_CONN_TO:  cfg_in.wrong_conn_timeout_ms = csr_data;
            REG_HOT_OFF_TO:     cfg_in.hot_off_timeout_ms    = csr_data;
            REG_FAILURE_TO:     cfg_in.failure_timeout_ms    = csr_data;
            REG_FILL_DELAY:     cfg_in.start_wait_ms         = csr_data;
            REG_SUPPLY_TO:      cfg_in.supply_timeout_ms     = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cold_high_temp        <= RST_COLD_HIGH_TEMP;
         cfg_ff.max_temp              <= RST_MAX_TEMP;
         cfg_ff.wrong_conn_timeout_ms <= RST_WRONG_CONN_TO;
         cfg_ff.hot_off_timeout_ms    <= RST_HOT_OFF_TO;
         cfg_ff.failure_timeout_ms    <= RST_FAILURE_TO;
         cfg_ff.start_wait_ms         <= RST_FILL_DELAY;
         cfg_ff.supply_timeout_ms     <= RST_SUPPLY_TO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/wftg_fill.sv
// Fill and stop command logic: start delay, valve drive and supply timer.
`timescale 1ns / 1ps

module wftg_fill (
   input  wftg_pkg::item_type       item,
   input  wftg_pkg::cfg_type        cfg,
   input  logic [wftg_pkg::FAULT_W-1:0] fault_code,
   input  wftg_pkg::fill_state_type cur,
   output wftg_pkg::fill_state_type nxt
);
   import wftg_pkg::*;

   logic              delay_done;
   logic [TIME_W-1:0] supply_sum;
   logic              fault_cold;
   logic              fault_hot_off;

   assign delay_done    = cur.start_delay_time >= cfg.start_wait_ms;
   assign supply_sum    = sat_add(cur.supply_time, item.elapsed_ms);
   assign fault_cold    = (fault_code == FAULT_COLD_ON) || (fault_code == FAULT_HOT_OFF);
   assign fault_hot_off = fault_code == FAULT_HOT_OFF;

   always_comb begin
      nxt = cur;
      case (item.cmd)
         CMD_FILL: begin
            if (!delay_done) begin
               // Still waiting out the start delay.
               nxt.start_delay_time = sat_add(cur.start_delay_time, item.elapsed_ms);
            end else begin
               // Valves follow the selection and the fault state.
               case (item.temp_choice)
                  CHOICE_HOT: begin
                     nxt.valve_drive[VALVE_COLD] = fault_cold;
                     nxt.valve_drive[VALVE_HOT]  = !fault_hot_off;
                     nxt.valve_drive[VALVE_SOFT] = 1'b0;
                  end
                  CHOICE_WARM: begin
                     nxt.valve_drive[VALVE_COLD] = 1'b1;
                     nxt.valve_drive[VALVE_HOT]  = !fault_hot_off;
                     nxt.valve_drive[VALVE_SOFT] = 1'b0;
                  end
                  CHOICE_COLD: begin
                     nxt.valve_drive[VALVE_COLD] = 1'b1;
                     nxt.valve_drive[VALVE_HOT]  = 1'b0;
                     nxt.valve_drive[VALVE_SOFT] = item.softener_stage;
                  end
                  default: nxt.valve_drive = cur.valve_drive;
               endcase
               // Supply timer wraps to zero and latches the error.
               if (supply_sum >= cfg.supply_timeout_ms) begin
                  nxt.supply_time       = '0;
                  nxt.supply_fault_flag = 1'b1;
               end else begin
                  nxt.supply_time = supply_sum;
               end
            end
         end
         CMD_STOP: begin
            nxt.start_delay_time = '0;
            nxt.supply_time      = '0;
            nxt.valve_drive      = '0;
         end
         default: nxt = cur;
      endcase
   end

endmodule

>>> rtl/core/wftg_mon.sv
// Temperature fault machine: wrong connection and overheat escalation.
`timescale 1ns / 1ps

module wftg_mon (
   input  wftg_pkg::item_type      item,
   input  wftg_pkg::cfg_type       cfg,
   input  wftg_pkg::mon_state_type cur,
   output wftg_pkg::mon_state_type nxt
);
   import wftg_pkg::*;

   logic [TEMP_W-1:0]  release_temp;
   logic [TIME_W-1:0]  wrong_sum;
   logic [TIME_W-1:0]  overheat_sum;
   logic               too_hot;
   logic [FAULT_W-1:0] fault_mid;

   // Release threshold saturates at zero for small limits.
   assign release_temp = (cfg.max_temp >= RELEASE_HYST) ? cfg.max_temp - RELEASE_HYST : '0;
   assign wrong_sum    = sat_add(cur.wrong_conn_time, item.elapsed_ms);
   assign overheat_sum = sat_add(cur.overheat_time, item.elapsed_ms);
   assign too_hot      = item.water_temp >= cfg.max_temp;
   assign fault_mid    = too_hot ? FAULT_COLD_ON : cur.fault_code;

   always_comb begin
      nxt = cur;
      case (item.temp_choice)
         CHOICE_COLD: begin
            // Hot water under a cold selection counts toward wrong connection.
            if (item.water_temp >= cfg.cold_high_temp) begin
               nxt.wrong_conn_time = wrong_sum;
               if (wrong_sum >= cfg.wrong_conn_timeout_ms) begin
                  nxt.fault_code = FAULT_WRONG_CONN;
               end
            end else begin
               nxt.wrong_conn_time = '0;
            end
         end
         CHOICE_WARM, CHOICE_HOT: begin
            nxt.wrong_conn_time = '0;
            nxt.fault_code      = fault_mid;
            if (fault_mid == FAULT_COLD_ON && item.water_temp <= release_temp) begin
               // Cooled down: back to normal.
               nxt.fault_code    = FAULT_NORMAL;
               nxt.overheat_time = '0;
            end else if (fault_mid == FAULT_COLD_ON && too_hot) begin
               // Overheat escalation.
               nxt.overheat_time = overheat_sum;
               if (overheat_sum >= cfg.hot_off_timeout_ms) begin
                  nxt.fault_code = FAULT_HOT_OFF;
                  if (overheat_sum >= cfg.failure_timeout_ms) begin
                     nxt.overheat_time = '0;
                     nxt.fault_code    = FAULT_FAILURE;
                  end
               end
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule

>>> rtl/core/water_fill_temp_guard.sv
// Top level of the water fill temperature guard.
`timescale 1ns / 1ps

// Valve and temperature guard for a washer fill. Each item is one tick that
// carries the elapsed milliseconds, the water temperature, the temperature
// selection, the softener-stage flag and a command (monitor, fill or stop),
// and produces exactly one result item with the valve drives, the fault code
// and the sticky supply error. An accepted item is held in an input register
// and finished, once the result register is free or being emptied, by one
// pass of logic that updates the state and loads the result register; one
// item is taken every cycle when the output is not stalled. A result passes
// through the input register and then the result register before it is shown.
// While a result waits, the input register can still take one more item.
// Configuration writes are always taken and should be made only while no item
// is in flight.
module water_fill_temp_guard (
   input  logic                        clock,
   input  logic                        reset,
   // Ticks. tdata from bit 0: cmd[1:0], elapsed_ms[17:2], water_temp[25:18],
   // temp_choice[27:26], softener_stage[28], zeros[31:29].
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [wftg_pkg::REQ_W-1:0]  req_tdata,
   // Results. tdata from bit 0: cold_valve_on[0], hot_valve_on[1],
   // softener_valve_on[2], temp_fault[5:3], supply_error[6], zero[7].
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [wftg_pkg::RSP_W-1:0]  rsp_tdata,
   // Configuration writes.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wftg_pkg::IDX_W-1:0]  csr_index,
   input  logic [wftg_pkg::TIME_W-1:0] csr_data
);
   import wftg_pkg::*;

   cfg_type        cfg;
   item_type       item_ff;
   logic           item_valid_ff;
   fill_state_type fill_ff;
   fill_state_type fill_in;
   mon_state_type  mon_ff;
   mon_state_type  mon_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;
   logic           rsp_valid_ff;
   logic           advance;
   logic           fire;

   wftg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: the held item finishes when the result register is free.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   // Fill logic sees the monitor's fault code from before this tick.
   wftg_fill u_fill (
      .item       (item_ff),
      .cfg        (cfg),
      .fault_code (mon_ff.fault_code),
      .cur        (fill_ff),
      .nxt        (fill_in)
   );

   wftg_mon u_mon (
      .item (item_ff),
      .cfg  (cfg),
      .cur  (mon_ff),
      .nxt  (mon_in)
   );

   assign rsp_data_in = {1'b0, fill_in.supply_fault_flag, mon_in.fault_code,
                         fill_in.valve_drive};

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_type'(req_tdata[$bits(item_type)-1:0]);
      end
   end

   // State update, one item per cycle while the result register can advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         mon_ff  <= '0;
      end else if (fire) begin
         fill_ff <= fill_in;
         mon_ff  <= mon_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
